/* rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared constants, codes, memory word layouts and small helper functions.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int TOP_ORD   = 10;
    localparam int NUM_ORD   = TOP_ORD + 1;
    localparam int PAGES     = 1 << TOP_ORD;
    localparam int IDX_W     = 10;
    localparam int ORD_W     = 4;
    localparam int REQ_ORD_W = 5;
    localparam int CNT_IN_W  = 16;
    localparam int TOT_W     = 11;
    localparam int CNT_W     = IDX_W + 1;
    localparam int SUM_W     = 2 * IDX_W + 1;
    localparam int FREE_W    = 11;
    localparam int FREE_SAT  = 2047;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_REQ  = 2'd1,
        ST_NO_BLOCK = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_INIT, S_DONE,
        S_A_SRCH, S_A_SPLIT,
        S_F_CHK, S_F_LOOP, S_F_TST, S_F_MRG, S_F_END,
        S_D_START, S_D_RD, S_D_WR2,
        S_P_START, S_P_CHK, S_P_LINK, S_P_RDH, S_P_W1, S_P_W2, S_P_FIN
    } t_state;

    typedef struct packed {
        logic             mark;
        logic [ORD_W-1:0] order;
    } t_mk;

    typedef struct packed {
        logic [IDX_W-1:0] next;
        logic [IDX_W-1:0] prev;
    } t_link;

    typedef struct packed {
        logic [IDX_W-1:0] mk_raddr;
        logic             mk_we;
        logic [IDX_W-1:0] mk_waddr;
        t_mk              mk_wdata;
        logic [IDX_W-1:0] ln_raddr;
        logic             ln_we_next;
        logic             ln_we_prev;
        logic [IDX_W-1:0] ln_waddr;
        t_link            ln_wdata;
    } t_mem_req;

    typedef struct packed {
        t_mk   mk;
        t_link ln;
    } t_mem_rsp;

    // Smallest order whose block size is at least n; n of zero gives an oversized order.
    function automatic logic [REQ_ORD_W-1:0] order_of(input logic [CNT_IN_W-1:0] n);
        logic [CNT_IN_W-1:0]  m;
        logic [REQ_ORD_W-1:0] o;
        m = n - CNT_IN_W'(1);
        o = '0;
        for (int i = 0; i < CNT_IN_W; i++) begin
            if (m[i]) begin
                o = REQ_ORD_W'(i + 1);
            end
        end
        return o;
    endfunction

    function automatic logic [ORD_W-1:0] floor_log2(input logic [TOT_W-1:0] t);
        logic [ORD_W-1:0] o;
        o = '0;
        for (int i = 0; i < TOT_W; i++) begin
            if (t[i]) begin
                o = ORD_W'(i);
            end
        end
        return o;
    endfunction

endpackage

/* rtl/bpa_state_mem.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator state memories
// Per-page head mark and order, and the per-page free list links, each a
// synchronous memory with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpa_state_mem
    import bpa_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    t_mk   mk_mem [PAGES];
    t_link ln_mem [PAGES];
    t_mk   r_mk_rd;
    t_link r_ln_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.mk_we) begin
            mk_mem[i_req.mk_waddr] <= i_req.mk_wdata;
        end
        r_mk_rd <= mk_mem[i_req.mk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ln_we_next) begin
            ln_mem[i_req.ln_waddr].next <= i_req.ln_wdata.next;
        end
        if (i_req.ln_we_prev) begin
            ln_mem[i_req.ln_waddr].prev <= i_req.ln_wdata.prev;
        end
        r_ln_rd <= ln_mem[i_req.ln_raddr];
    end

    assign o_rsp.mk = r_mk_rd;
    assign o_rsp.ln = r_ln_rd;

endmodule

/* rtl/bpa_ctrl.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator sequencer
// Runs initialise, allocate and free as sequences of list push and unlink
// steps against the state memories, and keeps per-order list heads, block
// counts and the free page total in registers.
// ----------------------------------------------------------------------------
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_op,
    input  logic [CNT_IN_W-1:0] i_page_count,
    input  logic [IDX_W-1:0]    i_page_index,
    input  logic                i_cfg_we,
    input  logic [TOT_W-1:0]    i_cfg_wdata,
    input  t_mem_rsp            i_rsp,
    output t_mem_req            o_req,
    output logic                busy,
    output logic                o_result_valid,
    output logic [1:0]          o_status,
    output logic [IDX_W-1:0]    o_block_index,
    output logic [ORD_W-1:0]    o_block_order,
    output logic [FREE_W-1:0]   o_free_cnt
);

    t_state           r_state, n_state, r_ret_p, n_ret_p, r_ret_d, n_ret_d;
    logic [ORD_W-1:0] r_ro, n_ro, r_o, n_o, r_co, n_co, r_sord, n_sord, r_dord, n_dord;
    logic [IDX_W-1:0] r_pg, n_pg, r_cur, n_cur, r_b, n_b, r_sidx, n_sidx, r_didx, n_didx;
    logic [IDX_W-1:0] r_p, n_p, r_n, n_n, r_h, n_h, r_t, n_t, r_clr, n_clr;
    logic             r_init, n_init;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_bidx, n_bidx;
    logic [ORD_W-1:0] r_bord, n_bord;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [TOT_W-1:0] r_total;
    logic [CNT_W-1:0] r_bpo [NUM_ORD];
    logic [IDX_W-1:0] r_head [NUM_ORD];

    logic                 r_valid;
    t_status              r_o_status;
    logic [IDX_W-1:0]     r_o_bidx;
    logic [ORD_W-1:0]     r_o_bord;
    logic [FREE_W-1:0]    r_o_free;

    logic [ORD_W-1:0]     ord_sel, k_init;
    logic [CNT_W-1:0]     bpo_rd, bpo_wdata;
    logic [IDX_W-1:0]     head_rd, head_wdata, buddy;
    logic                 bpo_we, head_we, bpo_clr, bad_req;
    logic [TOT_W-1:0]     tot_b;
    logic [REQ_ORD_W-1:0] ro_in;
    logic [SUM_W-1:0]     size_sel;
    t_mem_req             req;

    assign tot_b   = (r_total > TOT_W'(PAGES)) ? TOT_W'(PAGES) : r_total;
    assign k_init  = floor_log2(tot_b);
    assign ro_in   = order_of(i_page_count);
    assign bad_req = (i_page_count == '0) || (ro_in > REQ_ORD_W'(TOP_ORD));
    assign buddy   = r_cur ^ (IDX_W'(1) << r_co);

    always_comb begin
        unique case (r_state)
            S_A_SRCH:                      ord_sel = r_o;
            S_D_START, S_D_RD:             ord_sel = r_dord;
            S_P_LINK, S_P_FIN:             ord_sel = r_sord;
            S_INIT:                        ord_sel = k_init;
            default:                       ord_sel = r_o;
        endcase
    end

    assign bpo_rd   = r_bpo[ord_sel];
    assign head_rd  = r_head[ord_sel];
    assign size_sel = SUM_W'(1) << ord_sel;

    always_comb begin
        n_state = r_state; n_ret_p = r_ret_p; n_ret_d = r_ret_d;
        n_ro = r_ro; n_o = r_o; n_co = r_co; n_sord = r_sord; n_dord = r_dord;
        n_pg = r_pg; n_cur = r_cur; n_b = r_b; n_sidx = r_sidx; n_didx = r_didx;
        n_p = r_p; n_n = r_n; n_h = r_h; n_t = r_t; n_clr = r_clr; n_init = r_init;
        n_status = r_status; n_bidx = r_bidx; n_bord = r_bord; n_sum = r_sum;
        req = '0; bpo_we = 1'b0; bpo_wdata = '0; head_we = 1'b0; head_wdata = '0;
        bpo_clr = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                req.mk_we    = 1'b1;
                req.mk_waddr = r_clr;
                n_clr        = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(PAGES - 1)) begin
                    n_state = r_init ? S_INIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cur    = i_page_index;
                    n_ro     = ro_in[ORD_W-1:0];
                    n_o      = ro_in[ORD_W-1:0];
                    n_co     = ro_in[ORD_W-1:0];
                    n_bidx   = '0;
                    n_bord   = '0;
                    n_status = ST_OK;
                    unique case (t_op'(i_op))
                        OP_INIT: begin
                            n_init  = 1'b1;
                            n_clr   = '0;
                            bpo_clr = 1'b1;
                            n_sum   = '0;
                            n_state = S_CLEAR;
                        end
                        OP_ALLOC: begin
                            if (bad_req) begin
                                n_status = ST_BAD_REQ;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_A_SRCH;
                            end
                        end
                        OP_FREE: begin
                            if (bad_req) begin
                                n_status = ST_IGNORED;
                                n_state  = S_DONE;
                            end else begin
                                req.mk_raddr = i_page_index;
                                n_state      = S_F_CHK;
                            end
                        end
                        OP_NONE: begin
                            n_status = ST_IGNORED;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT: begin
                if (tot_b != '0) begin
                    req.mk_we      = 1'b1;
                    req.mk_waddr   = '0;
                    req.mk_wdata   = '{mark: 1'b1, order: k_init};
                    req.ln_we_next = 1'b1;
                    req.ln_we_prev = 1'b1;
                    req.ln_waddr   = '0;
                    bpo_we         = 1'b1;
                    bpo_wdata      = CNT_W'(1);
                    head_we        = 1'b1;
                    n_sum          = size_sel;
                    n_bord         = k_init;
                end
                n_state = S_DONE;
            end
            S_A_SRCH: begin
                if (bpo_rd != '0) begin
                    n_pg    = head_rd;
                    n_didx  = head_rd;
                    n_dord  = r_o;
                    n_ret_d = S_A_SPLIT;
                    n_state = S_D_START;
                end else if (r_o == ORD_W'(TOP_ORD)) begin
                    n_status = ST_NO_BLOCK;
                    n_state  = S_DONE;
                end else begin
                    n_o = r_o + ORD_W'(1);
                end
            end
            S_A_SPLIT: begin
                if (r_o > r_ro) begin
                    n_o     = r_o - ORD_W'(1);
                    n_sord  = r_o - ORD_W'(1);
                    n_sidx  = r_pg + (IDX_W'(1) << (r_o - ORD_W'(1)));
                    n_ret_p = S_A_SPLIT;
                    n_state = S_P_START;
                end else begin
                    n_bidx  = r_pg;
                    n_bord  = r_ro;
                    n_state = S_DONE;
                end
            end
            S_F_CHK: begin
                if (i_rsp.mk.mark) begin
                    n_status = ST_IGNORED;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_F_LOOP;
                end
            end
            S_F_LOOP: begin
                if (r_co < ORD_W'(TOP_ORD)) begin
                    n_b          = buddy;
                    req.mk_raddr = buddy;
                    n_state      = S_F_TST;
                end else begin
                    n_sidx  = r_cur;
                    n_sord  = r_co;
                    n_ret_p = S_F_END;
                    n_state = S_P_START;
                end
            end
            S_F_TST: begin
                if (({1'b0, r_b} >= tot_b) || !i_rsp.mk.mark || (i_rsp.mk.order != r_co)) begin
                    n_sidx  = r_cur;
                    n_sord  = r_co;
                    n_ret_p = S_F_END;
                    n_state = S_P_START;
                end else begin
                    n_didx  = r_b;
                    n_dord  = r_co;
                    n_ret_d = S_F_MRG;
                    n_state = S_D_START;
                end
            end
            S_F_MRG: begin
                if (r_b < r_cur) begin
                    n_cur = r_b;
                end
                n_co    = r_co + ORD_W'(1);
                n_state = S_F_LOOP;
            end
            S_F_END: begin
                n_bidx  = r_cur;
                n_bord  = r_co;
                n_state = S_DONE;
            end
            S_D_START: begin
                if (bpo_rd <= CNT_W'(1)) begin
                    bpo_we       = 1'b1;
                    req.mk_we    = 1'b1;
                    req.mk_waddr = r_didx;
                    if (bpo_rd == CNT_W'(1)) begin
                        n_sum = r_sum - size_sel;
                    end
                    n_state = r_ret_d;
                end else begin
                    req.ln_raddr = r_didx;
                    n_state      = S_D_RD;
                end
            end
            S_D_RD: begin
                n_p                 = i_rsp.ln.prev;
                n_n                 = i_rsp.ln.next;
                req.ln_we_next      = 1'b1;
                req.ln_waddr        = i_rsp.ln.prev;
                req.ln_wdata.next   = i_rsp.ln.next;
                bpo_we              = 1'b1;
                bpo_wdata           = bpo_rd - CNT_W'(1);
                if (head_rd == r_didx) begin
                    head_we    = 1'b1;
                    head_wdata = i_rsp.ln.next;
                end
                req.mk_we    = 1'b1;
                req.mk_waddr = r_didx;
                n_sum        = r_sum - size_sel;
                n_state      = S_D_WR2;
            end
            S_D_WR2: begin
                req.ln_we_prev    = 1'b1;
                req.ln_waddr      = r_n;
                req.ln_wdata.prev = r_p;
                n_state           = r_ret_d;
            end
            S_P_START: begin
                req.mk_raddr = r_sidx;
                n_state      = S_P_CHK;
            end
            S_P_CHK: begin
                if (i_rsp.mk.mark) begin
                    n_didx  = r_sidx;
                    n_dord  = (i_rsp.mk.order > ORD_W'(TOP_ORD)) ? ORD_W'(TOP_ORD)
                                                                 : i_rsp.mk.order;
                    n_ret_d = S_P_LINK;
                    n_state = S_D_START;
                end else begin
                    n_state = S_P_LINK;
                end
            end
            S_P_LINK: begin
                if (bpo_rd == '0) begin
                    req.ln_we_next = 1'b1;
                    req.ln_we_prev = 1'b1;
                    req.ln_waddr   = r_sidx;
                    req.ln_wdata   = '{next: r_sidx, prev: r_sidx};
                    n_state        = S_P_FIN;
                end else begin
                    n_h          = head_rd;
                    req.ln_raddr = head_rd;
                    n_state      = S_P_RDH;
                end
            end
            S_P_RDH: begin
                n_t            = i_rsp.ln.prev;
                req.ln_we_next = 1'b1;
                req.ln_we_prev = 1'b1;
                req.ln_waddr   = r_sidx;
                req.ln_wdata   = '{next: r_h, prev: i_rsp.ln.prev};
                n_state        = S_P_W1;
            end
            S_P_W1: begin
                req.ln_we_next    = 1'b1;
                req.ln_waddr      = r_t;
                req.ln_wdata.next = r_sidx;
                n_state           = S_P_W2;
            end
            S_P_W2: begin
                req.ln_we_prev    = 1'b1;
                req.ln_waddr      = r_h;
                req.ln_wdata.prev = r_sidx;
                n_state           = S_P_FIN;
            end
            S_P_FIN: begin
                head_we      = 1'b1;
                head_wdata   = r_sidx;
                bpo_we       = 1'b1;
                bpo_wdata    = bpo_rd + CNT_W'(1);
                req.mk_we    = 1'b1;
                req.mk_waddr = r_sidx;
                req.mk_wdata = '{mark: 1'b1, order: r_sord};
                n_sum        = r_sum + size_sel;
                n_state      = r_ret_p;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_init  <= 1'b0;
            r_sum   <= '0;
            r_total <= TOT_W'(PAGES);
            r_valid <= 1'b0;
            for (int i = 0; i < NUM_ORD; i++) begin
                r_bpo[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_init  <= n_init;
            r_sum   <= n_sum;
            r_valid <= (r_state == S_DONE);
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (bpo_clr) begin
                for (int i = 0; i < NUM_ORD; i++) begin
                    r_bpo[i] <= '0;
                end
            end else if (bpo_we) begin
                r_bpo[ord_sel] <= bpo_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret_p <= n_ret_p; r_ret_d <= n_ret_d;
        r_ro <= n_ro; r_o <= n_o; r_co <= n_co; r_sord <= n_sord; r_dord <= n_dord;
        r_pg <= n_pg; r_cur <= n_cur; r_b <= n_b; r_sidx <= n_sidx; r_didx <= n_didx;
        r_p <= n_p; r_n <= n_n; r_h <= n_h; r_t <= n_t;
        r_status <= n_status; r_bidx <= n_bidx; r_bord <= n_bord;
        if (head_we) begin
            r_head[ord_sel] <= head_wdata;
        end
        if (r_state == S_DONE) begin
            r_o_status <= r_status;
            r_o_bidx   <= r_bidx;
            r_o_bord   <= r_bord;
            r_o_free   <= (r_sum > SUM_W'(FREE_SAT)) ? FREE_W'(FREE_SAT) : r_sum[FREE_W-1:0];
        end
    end

    assign o_req          = req;
    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_status       = r_o_status;
    assign o_block_index  = r_o_bidx;
    assign o_block_order  = r_o_bord;
    assign o_free_cnt     = r_o_free;

endmodule

/* rtl/buddy_page_allocator_top.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator top level
// Command port in, one result strobe out, one configuration register.
// ----------------------------------------------------------------------------
// A transaction is taken at a clock edge with start high and busy low; it is
// an allocate, a free, an initialise or a no-op, selected by i_op. Each transaction
// gives exactly one result, shown for one cycle with o_result_valid high;
// the receiver cannot hold it off. i_cfg_we writes the managed page count,
// used at initialise and by every merge bound test; write it only while idle.
// The sequencer walks the state memories, one access per cycle: a rejected
// transaction goes straight to its result, an allocate runs an order search
// and then one split per order down to the request, a free one merge per
// level plus the final list push. Initialise sweeps the 1024-entry head mark
// memory, one entry a cycle. The next transaction may start in the cycle its
// predecessor's result is shown. After reset the same clearing sweep runs
// with busy high; the managed page count resets to 1024.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top
    import bpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_op,
    input  logic [CNT_IN_W-1:0] i_page_count,
    input  logic [IDX_W-1:0]    i_page_index,
    input  logic                i_cfg_we,
    input  logic [TOT_W-1:0]    i_cfg_wdata,
    output logic                o_result_valid,
    output logic [1:0]          o_status,
    output logic [IDX_W-1:0]    o_block_index,
    output logic [ORD_W-1:0]    o_block_order,
    output logic [FREE_W-1:0]   o_free_cnt
);

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    bpa_state_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    bpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_op           (i_op),
        .i_page_count   (i_page_count),
        .i_page_index   (i_page_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rsp          (mem_rsp),
        .o_req          (mem_req),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_block_index  (o_block_index),
        .o_block_order  (o_block_order),
        .o_free_cnt     (o_free_cnt)
    );

endmodule

/* rtl/bpa_checker.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator port checker
// Watches the top level ports for transaction and result ordering faults,
// for failed results that report a block and for out-of-range block orders.
module bpa_checker
    import bpa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_result_valid,
    input logic [1:0]          o_status,
    input logic [IDX_W-1:0]    o_block_index,
    input logic [ORD_W-1:0]    o_block_order
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("Accepted transaction did not raise busy.");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("Result strobe held for more than one cycle.");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> $past(busy))
        else $error("Result appeared without a transaction in progress.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status != ST_OK) |-> (o_block_index == '0) && (o_block_order == '0))
        else $error("Failed transaction reported a block.");

    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_block_order <= ORD_W'(TOP_ORD))
        else $error("Reported block order out of range.");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (.*);
